// ----- rtl/soct_pkg.sv -----
// Shared types, constants and helpers for the socket owner cache table.
// No dependencies; used by soct_mem, soct_match and the top level.
package soct_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int ADDR_W      = 64;
  localparam int PORT_W      = 16;
  localparam int OWNER_W     = 31;
  localparam int STAMP_W     = 48;
  localparam int AGE_W       = 20;
  localparam int SLOT_W      = 6;
  localparam int STATUS_W    = 3;

  localparam logic [7:0]       UDP_PROTO   = 8'd17;
  localparam logic [AGE_W-1:0] MAX_AGE_RST = 20'd7000;

  typedef enum logic [STATUS_W-1:0] {
    ST_MISS     = 3'd0,
    ST_HIT      = 3'd1,
    ST_UDP_HIT  = 3'd2,
    ST_INSERTED = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // Captured request
  typedef struct packed {
    logic               func;
    logic               is_v6;
    logic [7:0]         protocol;
    logic [ADDR_W-1:0]  src_addr_hi;
    logic [ADDR_W-1:0]  src_addr_lo;
    logic [PORT_W-1:0]  src_port;
    logic [ADDR_W-1:0]  dst_addr_hi;
    logic [ADDR_W-1:0]  dst_addr_lo;
    logic [PORT_W-1:0]  dst_port;
    logic [OWNER_W-1:0] owner_in;
    logic [STAMP_W-1:0] now_ms;
  } req_t;

  // One table entry as held in memory
  typedef struct packed {
    logic               is_v6;
    logic [7:0]         protocol;
    logic [PORT_W-1:0]  src_port;
    logic [PORT_W-1:0]  dst_port;
    logic [ADDR_W-1:0]  src_hi;
    logic [ADDR_W-1:0]  src_lo;
    logic [ADDR_W-1:0]  dst_hi;
    logic [ADDR_W-1:0]  dst_lo;
    logic [OWNER_W-1:0] owner;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Result of checking one entry against the request
  typedef struct packed {
    logic live;
    logic hit;
  } chk_t;

  function automatic entry_t make_entry(input req_t r);
    entry_t e;
    e.is_v6    = r.is_v6;
    e.protocol = r.protocol;
    e.src_port = r.src_port;
    e.dst_port = r.dst_port;
    e.src_hi   = r.src_addr_hi;
    e.src_lo   = r.src_addr_lo;
    e.dst_hi   = r.dst_addr_hi;
    e.dst_lo   = r.dst_addr_lo;
    e.owner    = r.owner_in;
    e.stamp    = r.now_ms;
    return e;
  endfunction

endpackage

// ----- rtl/soct_mem.sv -----
// Entry store: single-port-write, registered-read synchronous memory.
// Depends on soct_pkg for entry_t.
module soct_mem import soct_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IDX_W   = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ----- rtl/soct_match.sv -----
// Liveness and wildcard tuple compare of one stored entry against a request.
// Depends on soct_pkg for req_t, entry_t and chk_t.
module soct_match import soct_pkg::*; (
  input  req_t             req,
  input  entry_t           ent,
  input  logic [AGE_W-1:0] max_age,
  output chk_t             chk
);

  // v4: low 32 bits only; stored all-zero is a wildcard
  function automatic logic addr_ok(input logic [ADDR_W-1:0] shi,
                                   input logic [ADDR_W-1:0] slo,
                                   input logic [ADDR_W-1:0] hi,
                                   input logic [ADDR_W-1:0] lo,
                                   input logic v6);
    logic ok;
    if (v6) begin
      ok = (shi == hi && slo == lo) || (shi == '0 && slo == '0);
    end else begin
      ok = (slo[31:0] == lo[31:0]) || (slo[31:0] == 32'd0);
    end
    return ok;
  endfunction

  logic [STAMP_W-1:0] age;
  logic               key_ok;

  assign age = req.now_ms - ent.stamp;

  assign key_ok = (ent.is_v6 == req.is_v6) && (ent.protocol == req.protocol) &&
                  (ent.src_port == req.src_port) &&
                  (ent.dst_port == req.dst_port || ent.dst_port == '0);

  always_comb begin
    chk.live = (age <= STAMP_W'(max_age));
    chk.hit  = chk.live && key_ok &&
               addr_ok(ent.src_hi, ent.src_lo, req.src_addr_hi, req.src_addr_lo,
                       req.is_v6) &&
               addr_ok(ent.dst_hi, ent.dst_lo, req.dst_addr_hi, req.dst_addr_lo,
                       req.is_v6);
  end

endmodule

// ----- rtl/socket_owner_cache_table_top.sv -----
// Socket owner cache table, top level: request sequencer, age register, count.
// Depends on soct_pkg, soct_mem and soct_match.
//
// Issue a request by holding start high while busy is low; the request is
// taken at that edge and busy rises until the result is out. Each request
// gives exactly one result, shown for a single cycle with done high; there
// is no back-pressure, so the receiver must take it in that cycle. A request
// reads the entries from slot 0 upward, one memory read per cycle, and stops
// at the first hit (lookup) or first expired slot (insert); otherwise the scan
// runs to the end of the entry count (a miss, an append or a full table).
// The entry memory has a single read port, so slots are read one at a time.
// A new request may be started in the cycle done is high. max_age_ms is
// written with max_age_we and should only change while the block is idle.
// Table memory is not cleared at reset; only slots below the entry count are
// ever read.
module socket_owner_cache_table_top import soct_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                func,
  input  logic                is_v6,
  input  logic [7:0]          protocol,
  input  logic [ADDR_W-1:0]   src_addr_hi,
  input  logic [ADDR_W-1:0]   src_addr_lo,
  input  logic [PORT_W-1:0]   src_port,
  input  logic [ADDR_W-1:0]   dst_addr_hi,
  input  logic [ADDR_W-1:0]   dst_addr_lo,
  input  logic [PORT_W-1:0]   dst_port,
  input  logic [OWNER_W-1:0]  owner_in,
  input  logic [STAMP_W-1:0]  now_ms,
  input  logic                max_age_we,
  input  logic [AGE_W-1:0]    max_age_ms,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [OWNER_W-1:0]  owner_out,
  output logic [SLOT_W-1:0]   slot
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t             state, state_next;
  req_t               req, req_next;
  logic [CNT_W-1:0]   count, count_next;    // live table length
  logic [CNT_W-1:0]   rd_idx, rd_idx_next;  // next slot to read
  logic               chk_vld, chk_vld_next;
  logic [IDX_W-1:0]   chk_idx, chk_idx_next; // slot whose data is on rd_data
  logic [AGE_W-1:0]   max_age;
  logic               done_next;
  logic [STATUS_W-1:0] status_next;
  logic [OWNER_W-1:0] owner_next;
  logic [SLOT_W-1:0]  slot_next;

  logic               rd_en;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             rd_data;
  entry_t             wr_data;
  chk_t               chk;
  logic               last;

  soct_mem #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  soct_match u_match (
    .req     (req),
    .ent     (rd_data),
    .max_age (max_age),
    .chk     (chk)
  );

  assign busy    = (state != S_IDLE);
  assign wr_data = make_entry(req);
  // checked slot is the final one below the count
  assign last    = (CNT_W'(chk_idx) + CNT_W'(1)) == count;

  always_comb begin
    state_next   = state;
    req_next     = req;
    count_next   = count;
    rd_idx_next  = rd_idx;
    chk_vld_next = 1'b0;
    chk_idx_next = chk_idx;
    done_next    = 1'b0;
    status_next  = status;
    owner_next   = owner_out;
    slot_next    = slot;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = chk_idx;

    case (state)
      S_IDLE: begin
        if (start) begin
          req_next.func        = func;
          req_next.is_v6       = is_v6;
          req_next.protocol    = protocol;
          req_next.src_addr_hi = src_addr_hi;
          req_next.src_addr_lo = src_addr_lo;
          req_next.src_port    = src_port;
          req_next.dst_addr_hi = dst_addr_hi;
          req_next.dst_addr_lo = dst_addr_lo;
          req_next.dst_port    = dst_port;
          req_next.owner_in    = owner_in;
          req_next.now_ms      = now_ms;
          rd_idx_next          = '0;
          state_next           = (count == '0) ? S_FIN : S_SCAN;
        end
      end

      S_SCAN: begin
        rd_en        = (rd_idx < count);
        chk_vld_next = rd_en;
        chk_idx_next = rd_idx[IDX_W-1:0];
        if (rd_en) begin
          rd_idx_next = rd_idx + CNT_W'(1);
        end
        if (chk_vld) begin
          if (req.func == FUNC_LOOKUP && chk.hit) begin
            done_next    = 1'b1;
            slot_next    = SLOT_W'(chk_idx);
            chk_vld_next = 1'b0;
            state_next   = S_IDLE;
            if (req.protocol == UDP_PROTO) begin
              status_next = ST_UDP_HIT;
              owner_next  = '0;
            end else begin
              status_next = ST_HIT;
              owner_next  = rd_data.owner;
            end
          end else if (req.func == FUNC_INSERT && !chk.live) begin
            // reuse the first expired slot
            wr_en        = 1'b1;
            done_next    = 1'b1;
            status_next  = ST_INSERTED;
            owner_next   = '0;
            slot_next    = SLOT_W'(chk_idx);
            chk_vld_next = 1'b0;
            state_next   = S_IDLE;
          end else if (last) begin
            chk_vld_next = 1'b0;
            state_next   = S_FIN;
          end
        end
      end

      S_FIN: begin
        done_next  = 1'b1;
        owner_next = '0;
        slot_next  = '0;
        state_next = S_IDLE;
        if (req.func == FUNC_LOOKUP) begin
          status_next = ST_MISS;
        end else if (count == CNT_FULL) begin
          status_next = ST_FULL;
        end else begin
          // append
          wr_en       = 1'b1;
          wr_addr     = count[IDX_W-1:0];
          status_next = ST_INSERTED;
          slot_next   = SLOT_W'(count);
          count_next  = count + CNT_W'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      chk_vld <= 1'b0;
      done    <= 1'b0;
      max_age <= MAX_AGE_RST;
    end else begin
      state   <= state_next;
      count   <= count_next;
      chk_vld <= chk_vld_next;
      done    <= done_next;
      if (max_age_we) begin
        max_age <= max_age_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    req       <= req_next;
    rd_idx    <= rd_idx_next;
    chk_idx   <= chk_idx_next;
    status    <= status_next;
    owner_out <= owner_next;
    slot      <= slot_next;
  end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking bench for socket_owner_cache_table_top: random lookup and insert requests
// are scored against a cycle-free shadow of the table. Depends on rtl/soct_pkg.sv and the RTL.
// Runs stand-alone; the simulator seed picks the random content.
module tb_top import soct_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH   = ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 8;
  localparam int PHASE_REQS  = 250;

  // What one request is expected to give back
  typedef struct packed {
    status_t            st;
    logic [OWNER_W-1:0] own;
    logic [SLOT_W-1:0]  slt;
  } sock_result_t;

  logic clk;
  logic rst = 1'b1;

  // Request side: ports mirror req_reg, start marks it valid
  logic start = 1'b0;
  req_t req_reg = '0;
  logic busy;

  // Age register write port
  logic             cfg_age_we = 1'b0;
  logic [AGE_W-1:0] cfg_age    = MAX_AGE_RST;

  logic                done;
  logic [STATUS_W-1:0] status;
  logic [OWNER_W-1:0]  owner_out;
  logic [SLOT_W-1:0]   slot;

  // Shadow of the table, updated as each request is taken
  entry_t           sock_tbl [TBL_DEPTH];
  int unsigned      sock_count = 0;
  logic [AGE_W-1:0] age_limit  = MAX_AGE_RST;

  req_t         req_backlog   [$];  // requests waiting for the driver
  sock_result_t owed_results  [$];  // results the block still owes, oldest first
  req_t         seen_q        [$];  // recently inserted tuples, used to build hitting lookups

  logic [STAMP_W-1:0] gen_clock = '0;  // millisecond clock of the request generator
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned errors     = 0;
  int unsigned cycles     = 0;

  socket_owner_cache_table_top #(
    .ENTRIES(TBL_DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (req_reg.func),
    .is_v6      (req_reg.is_v6),
    .protocol   (req_reg.protocol),
    .src_addr_hi(req_reg.src_addr_hi),
    .src_addr_lo(req_reg.src_addr_lo),
    .src_port   (req_reg.src_port),
    .dst_addr_hi(req_reg.dst_addr_hi),
    .dst_addr_lo(req_reg.dst_addr_lo),
    .dst_port   (req_reg.dst_port),
    .owner_in   (req_reg.owner_in),
    .now_ms     (req_reg.now_ms),
    .max_age_we (cfg_age_we),
    .max_age_ms (cfg_age),
    .done       (done),
    .status     (status),
    .owner_out  (owner_out),
    .slot       (slot)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow table
  // ---------------------------------------------------------------------------

  // Age is taken modulo 2^48, so a clock that steps back makes an entry very old
  function automatic bit entry_live(input int unsigned idx, input logic [STAMP_W-1:0] now);
    logic [STAMP_W-1:0] age;
    age = now - sock_tbl[idx].stamp;
    return age <= {{(STAMP_W-AGE_W){1'b0}}, age_limit};
  endfunction

  // A stored all-zero address matches anything; IPv4 looks at the low 32 bits only
  function automatic bit addr_match(input logic [ADDR_W-1:0] shi, slo, hi, lo, input bit v6);
    if (!v6)
      return (slo[31:0] == lo[31:0]) || (slo[31:0] == 32'd0);
    return ({shi, slo} == {hi, lo}) || ({shi, slo} == '0);
  endfunction

  // Works out the result of one request and applies an insert to the shadow table
  function automatic sock_result_t resolve_request(input req_t r);
    sock_result_t res;
    entry_t       e;
    int unsigned  k;
    int unsigned  pick;
    bit           found;
    res.st = ST_MISS;
    res.own = '0;
    res.slt = '0;
    found = 1'b0;
    pick = 0;
    if (r.func == FUNC_LOOKUP) begin
      // first live entry that matches, scanning from slot 0
      for (k = 0; k < sock_count; k++) begin
        e = sock_tbl[k];
        if (!found && entry_live(k, r.now_ms) && e.is_v6 == r.is_v6 &&
            e.protocol == r.protocol && e.src_port == r.src_port &&
            (e.dst_port == r.dst_port || e.dst_port == '0) &&
            addr_match(e.src_hi, e.src_lo, r.src_addr_hi, r.src_addr_lo, r.is_v6) &&
            addr_match(e.dst_hi, e.dst_lo, r.dst_addr_hi, r.dst_addr_lo, r.is_v6)) begin
          found = 1'b1;
          pick = k;
        end
      end
      if (found) begin
        res.slt = pick[SLOT_W-1:0];
        if (r.protocol == UDP_PROTO) begin
          res.st = ST_UDP_HIT;  // UDP owner is held back
        end else begin
          res.st = ST_HIT;
          res.own = sock_tbl[pick].owner;
        end
      end
    end else begin
      // reuse the first expired slot, else append, else the table is full
      for (k = 0; k < sock_count; k++) begin
        if (!found && !entry_live(k, r.now_ms)) begin
          found = 1'b1;
          pick = k;
        end
      end
      if (!found && sock_count < TBL_DEPTH) begin
        found = 1'b1;
        pick = sock_count;
        sock_count++;
      end
      if (found) begin
        e.is_v6 = r.is_v6;
        e.protocol = r.protocol;
        e.src_port = r.src_port;
        e.dst_port = r.dst_port;
        e.src_hi = r.src_addr_hi;
        e.src_lo = r.src_addr_lo;
        e.dst_hi = r.dst_addr_hi;
        e.dst_lo = r.dst_addr_lo;
        e.owner = r.owner_in;
        e.stamp = r.now_ms;
        sock_tbl[pick] = e;
        res.st = ST_INSERTED;
        res.slt = pick[SLOT_W-1:0];
      end else begin
        res.st = ST_FULL;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request generation
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // Random tuple; ports come from a small pool so that keys collide now and then
  function automatic req_t fresh_tuple(input logic fn);
    req_t r;
    r = '0;
    r.func = fn;
    r.is_v6 = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       r.protocol = 8'd6;
      1:       r.protocol = UDP_PROTO;
      default: r.protocol = 8'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       r.src_port = '1;
      1:       r.src_port = PORT_W'($urandom);
      default: r.src_port = PORT_W'($urandom_range(0, 7));
    endcase
    case ($urandom_range(0, 4))
      0:       r.dst_port = '0;
      1:       r.dst_port = PORT_W'($urandom);
      default: r.dst_port = PORT_W'($urandom_range(1, 8));
    endcase
    r.src_addr_hi = rnd64();
    r.src_addr_lo = rnd64();
    r.dst_addr_hi = rnd64();
    r.dst_addr_lo = rnd64();
    // wildcard addresses; for IPv4 the ignored upper bits stay random
    if ($urandom_range(0, 5) == 0) begin
      if (r.is_v6) {r.src_addr_hi, r.src_addr_lo} = '0;
      else r.src_addr_lo[31:0] = '0;
    end
    if ($urandom_range(0, 5) == 0) begin
      if (r.is_v6) {r.dst_addr_hi, r.dst_addr_lo} = '0;
      else r.dst_addr_lo[31:0] = '0;
    end
    r.owner_in = OWNER_W'($urandom);
    r.now_ms = gen_clock;
    return r;
  endfunction

  // Lookup that should hit the given tuple; wildcard and ignored bits get fresh values.
  // With spoil set one key field is disturbed, which mostly turns it into a miss.
  function automatic req_t probe_of(input req_t k, input bit spoil);
    req_t r;
    r = k;
    r.func = FUNC_LOOKUP;
    r.owner_in = OWNER_W'($urandom);
    r.now_ms = gen_clock;
    if (k.dst_port == '0) r.dst_port = PORT_W'($urandom);
    if (!k.is_v6) begin
      r.src_addr_hi = rnd64();
      r.dst_addr_hi = rnd64();
      r.src_addr_lo[63:32] = $urandom;
      r.dst_addr_lo[63:32] = $urandom;
      if (k.src_addr_lo[31:0] == '0) r.src_addr_lo[31:0] = $urandom;
      if (k.dst_addr_lo[31:0] == '0) r.dst_addr_lo[31:0] = $urandom;
    end else begin
      if ({k.src_addr_hi, k.src_addr_lo} == '0)
        {r.src_addr_hi, r.src_addr_lo} = {rnd64(), rnd64()};
      if ({k.dst_addr_hi, k.dst_addr_lo} == '0)
        {r.dst_addr_hi, r.dst_addr_lo} = {rnd64(), rnd64()};
    end
    if (spoil) begin
      case ($urandom_range(0, 4))
        0:       r.src_port = r.src_port ^ 16'h0001;
        1:       r.is_v6 = ~r.is_v6;
        2:       r.protocol = r.protocol ^ 8'h10;
        3:       r.dst_port = r.dst_port + 16'd1;
        default: r.src_addr_lo[0] = ~r.src_addr_lo[0];
      endcase
    end
    return r;
  endfunction

  // Clock mostly creeps forward; unless the age limit is at its maximum it sometimes leaps or steps back
  function automatic void advance_clock(input int unsigned step_max);
    int unsigned roll;
    roll = $urandom_range(0, 199);
    if (age_limit != '1 && roll == 0)
      gen_clock = STAMP_W'(rnd64());
    else if (age_limit != '1 && roll == 1)
      gen_clock = gen_clock - STAMP_W'($urandom_range(1, 50));
    else
      gen_clock = gen_clock + STAMP_W'($urandom_range(0, step_max));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of requests with random gaps. A request is taken at an edge
  // with start high and busy low; its result is predicted at that same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    bit took;
    bit nxt_start;
    if (rst) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      nxt_start = start && !took;
      if (took) begin
        owed_results.push_back(resolve_request(req_reg));
        if (burst_left > 0) burst_left--;
      end
      if (!start || took) begin
        nxt_start = 1'b0;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          // a third of the bursts follow on with no gap at all
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_backlog.size() > 0) begin
          req_reg <= req_backlog.pop_front();
          nxt_start = 1'b1;
        end
      end
      start <= nxt_start;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: done lasts one cycle and cannot be held off, so every edge with
  // done high carries a result that must match the oldest one owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    sock_result_t want;
    if (!rst && done) begin
      if (owed_results.size() == 0) begin
        errors++;
        if (errors < 50)
          $display("%0t: result with no request outstanding: status=%0d owner=%0h slot=%0d",
                   $time, status, owner_out, slot);
      end else begin
        want = owed_results.pop_front();
        if (status !== want.st || owner_out !== want.own || slot !== want.slt) begin
          errors++;
          if (errors < 50)
            $display({"%0t: mismatch: expected status=%0d owner=%0h slot=%0d, ",
                      "got status=%0d owner=%0h slot=%0d"},
                     $time, want.st, want.own, want.slt, status, owner_out, slot);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Block is idle once every request is taken and answered
  task automatic wait_drained();
    while (req_backlog.size() != 0 || owed_results.size() != 0 || start || busy)
      @(posedge clk);
  endtask

  // Age limit only changes while the block is idle; the shadow follows at once
  task automatic write_age(input logic [AGE_W-1:0] v);
    @(posedge clk);
    cfg_age_we <= 1'b1;
    cfg_age <= v;
    @(posedge clk);
    cfg_age_we <= 1'b0;
    age_limit = v;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: directed cases at the reset age limit, then random phases, each
  // under its own age limit. Requests are queued at the falling edge.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    req_t a, b, c, d, z, r;
    logic [AGE_W-1:0] ages [PHASES];
    int unsigned step;
    int unsigned idx;
    int ph, n;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    gen_clock = 48'd1000;
    // lookup on an empty table
    req_backlog.push_back(fresh_tuple(FUNC_LOOKUP));
    // plain IPv4 TCP entry with the largest owner id, then a hit on it
    a = fresh_tuple(FUNC_INSERT);
    a.is_v6 = 1'b0;
    a.protocol = 8'd6;
    a.src_port = '1;
    a.dst_port = 16'd80;
    a.src_addr_lo[0] = 1'b1;
    a.dst_addr_lo[0] = 1'b1;
    a.owner_in = '1;
    req_backlog.push_back(a);
    req_backlog.push_back(probe_of(a, 1'b0));
    // UDP entry with wildcard destination port: hit is suppressed
    b = a;
    b.protocol = UDP_PROTO;
    b.src_port = '0;
    b.dst_port = '0;
    b.owner_in = OWNER_W'($urandom);
    req_backlog.push_back(b);
    r = probe_of(b, 1'b0);
    r.dst_port = '1;
    req_backlog.push_back(r);
    // IPv6 entry with an all-zero source address and owner zero
    c = fresh_tuple(FUNC_INSERT);
    c.is_v6 = 1'b1;
    c.protocol = '1;
    {c.src_addr_hi, c.src_addr_lo} = '0;
    {c.dst_addr_hi, c.dst_addr_lo} = '1;
    c.src_port = '1;
    c.dst_port = '1;
    c.owner_in = '0;
    req_backlog.push_back(c);
    req_backlog.push_back(probe_of(c, 1'b0));
    // IPv4 entry whose destination is zero in the low 32 bits only
    d = fresh_tuple(FUNC_INSERT);
    d.is_v6 = 1'b0;
    d.protocol = '0;
    d.src_addr_hi = '1;
    d.src_addr_lo[31:0] = '1;
    d.dst_addr_lo = {32'hFFFF_FFFF, 32'h0};
    req_backlog.push_back(d);
    req_backlog.push_back(probe_of(d, 1'b0));
    // version and source port mismatches
    r = probe_of(a, 1'b0);
    r.is_v6 = 1'b1;
    req_backlog.push_back(r);
    r = probe_of(a, 1'b0);
    r.src_port = 16'hFFFE;
    req_backlog.push_back(r);
    // duplicate insert is appended; the lookup still takes the lower slot
    r = a;
    r.owner_in = 31'h1234;
    req_backlog.push_back(r);
    req_backlog.push_back(probe_of(a, 1'b0));
    // age exactly at the limit, then one past it
    gen_clock = a.now_ms + 48'd7000;
    req_backlog.push_back(probe_of(a, 1'b0));
    gen_clock = gen_clock + 48'd1;
    req_backlog.push_back(probe_of(a, 1'b0));
    // insert reuses the first expired slot
    req_backlog.push_back(fresh_tuple(FUNC_INSERT));
    // clock wraps between insert and lookup
    gen_clock = '1;
    r = fresh_tuple(FUNC_INSERT);
    r.is_v6 = 1'b1;
    req_backlog.push_back(r);
    gen_clock = 48'd5;
    req_backlog.push_back(probe_of(r, 1'b0));
    // all-zero entry matches any address and destination port
    z = '0;
    z.func = FUNC_INSERT;
    z.now_ms = gen_clock;
    req_backlog.push_back(z);
    req_backlog.push_back(probe_of(z, 1'b0));
    // all-ones lookup
    r = '1;
    r.func = FUNC_LOOKUP;
    r.now_ms = gen_clock;
    req_backlog.push_back(r);
    wait_drained();

    // Age limits per phase, extremes included; a long limit with a slow clock
    // fills the table, so the full case shows up there
    ages[0] = '0;
    ages[1] = '1;
    ages[2] = 20'd7000;
    ages[3] = 20'd1;
    ages[4] = 20'd250;
    ages[5] = AGE_W'($urandom_range(2, 100000));
    ages[6] = '1;
    ages[7] = AGE_W'($urandom_range(2, 100000));

    for (ph = 0; ph < PHASES; ph++) begin
      write_age(ages[ph]);
      step = (ages[ph] > 100000) ? 3 : ages[ph] / 16 + 1;
      @(negedge clk);
      for (n = 0; n < PHASE_REQS; n++) begin
        advance_clock(step);
        if (seen_q.size() == 0 || $urandom_range(0, 99) < 45) begin
          if (seen_q.size() > 0 && $urandom_range(0, 7) == 0) begin
            // re-insert of a known tuple under a new owner
            r = seen_q[$urandom_range(0, seen_q.size() - 1)];
            r.owner_in = OWNER_W'($urandom);
            r.now_ms = gen_clock;
          end else begin
            r = fresh_tuple(FUNC_INSERT);
          end
          seen_q.push_back(r);
          if (seen_q.size() > 96) seen_q.delete(0);
        end else if ($urandom_range(0, 99) < 80) begin
          // lookups lean towards recent inserts, which are more likely still live
          idx = seen_q.size() - 1 -
                $urandom_range(0, (seen_q.size() > 48) ? 47 : seen_q.size() - 1);
          r = probe_of(seen_q[idx], $urandom_range(0, 9) < 2);
        end else begin
          r = fresh_tuple(FUNC_LOOKUP);
        end
        req_backlog.push_back(r);
      end
      wait_drained();
    end

    // let any stray result show up before judging
    repeat (TBL_DEPTH + 8) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/soct_pkg.sv
rtl/soct_mem.sv
rtl/soct_match.sv
rtl/socket_owner_cache_table_top.sv
sim/tb_top.sv
